// ----- rtl/rvde_pkg.sv -----
// Shared types, constants and codes of the RV32IM decode-execute block.
package rvde_pkg;

    localparam int unsigned DMEM_WORDS = 4096;
    localparam int unsigned DMEM_AW    = $clog2(DMEM_WORDS);
    localparam logic [31:0] DMEM_BYTES = 32'(DMEM_WORDS * 4);

    localparam logic [31:0] RESET_PC_DEFAULT  = 32'h8000_0000;
    localparam logic [31:0] DMEM_BASE_DEFAULT = 32'h8000_0000;

    // configuration register indexes
    localparam logic [7:0] CFG_RESET_PC  = 8'd0;
    localparam logic [7:0] CFG_DMEM_BASE = 8'd1;

    // opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
    localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INSN_MRET   = 32'h3020_0073;

    localparam logic [11:0] CSR_MSTATUS = 12'h300;
    localparam logic [11:0] CSR_MTVEC   = 12'h305;
    localparam logic [11:0] CSR_MEPC    = 12'h341;
    localparam logic [11:0] CSR_MCAUSE  = 12'h342;
    localparam logic [31:0] CAUSE_ECALL = 32'd11;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // multiply/divide funct3 codes
    localparam logic [2:0] MD_MUL    = 3'd0;
    localparam logic [2:0] MD_MULH   = 3'd1;
    localparam logic [2:0] MD_MULHSU = 3'd2;
    localparam logic [2:0] MD_MULHU  = 3'd3;
    localparam logic [2:0] MD_DIV    = 3'd4;
    localparam logic [2:0] MD_DIVU   = 3'd5;
    localparam logic [2:0] MD_REM    = 3'd6;
    localparam logic [2:0] MD_REMU   = 3'd7;

    localparam logic [4:0] REG_A0 = 5'd10;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_BADMEM  = 2'd3;

    typedef struct packed {
        logic       start;
        logic [2:0] f3;
    } t_md_req;

endpackage

// ----- rtl/rvde_ram.sv -----
// Generic single-port-write, registered-read RAM.
module rvde_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/rvde_muldiv.sv -----
// Multiply unit (one registered product) and 32-step restoring divider.
module rvde_muldiv
    import rvde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_md_req     i_req,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_result
);
    localparam logic [1:0] MS_IDLE = 2'd0;
    localparam logic [1:0] MS_MUL  = 2'd1;
    localparam logic [1:0] MS_DIV  = 2'd2;
    localparam logic [1:0] MS_DONE = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [4:0]  r_cnt;
    logic [2:0]  r_f3;
    logic [31:0] r_a, r_b, r_mb, r_quo, r_rem;
    logic [63:0] r_prod;
    logic        r_na, r_nb;

    logic        a_neg, b_neg, signed_op;
    logic [32:0] shifted, diff;
    logic [31:0] mulh;

    assign signed_op = (i_req.f3 == MD_DIV) || (i_req.f3 == MD_REM);
    assign a_neg     = signed_op & i_a[31];
    assign b_neg     = signed_op & i_b[31];

    assign shifted = {r_rem, r_quo[31]};
    assign diff    = shifted - {1'b0, r_mb};

    always_comb begin
        n_state = r_state;
        case (r_state)
            MS_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.f3[2]) ? MS_DIV : MS_MUL;
                end
            end
            MS_MUL:  n_state = MS_DONE;
            MS_DIV:  n_state = (r_cnt == 5'd31) ? MS_DONE : MS_DIV;
            MS_DONE: n_state = MS_IDLE;
            default: n_state = MS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == MS_IDLE && i_req.start) begin
            r_f3   <= i_req.f3;
            r_a    <= i_a;
            r_b    <= i_b;
            r_na   <= a_neg;
            r_nb   <= b_neg;
            r_mb   <= b_neg ? (32'd0 - i_b) : i_b;
            r_quo  <= a_neg ? (32'd0 - i_a) : i_a;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_prod <= {32'd0, i_a} * {32'd0, i_b};
        end else if (r_state == MS_DIV) begin
            r_cnt <= r_cnt + 5'd1;
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= shifted[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    // signed high word from the unsigned product
    assign mulh = r_prod[63:32] - (r_a[31] ? r_b : 32'd0) - (r_b[31] ? r_a : 32'd0);

    always_comb begin
        case (r_f3)
            MD_MUL:   o_result = r_prod[31:0];
            MD_MULH:  o_result = mulh;
            MD_MULHU: o_result = r_prod[63:32];
            MD_DIV:   o_result = (r_b == 32'd0) ? 32'hffff_ffff
                               : ((r_na != r_nb) ? (32'd0 - r_quo) : r_quo);
            MD_DIVU:  o_result = r_quo;
            MD_REM:   o_result = (r_b == 32'd0) ? r_a
                               : (r_na ? (32'd0 - r_rem) : r_rem);
            MD_REMU:  o_result = r_rem;
            default:  o_result = '0;
        endcase
    end

    assign o_done = (r_state == MS_DONE);
endmodule

// ----- rtl/rv32im_decode_execute.sv -----
// RV32IM decode-execute top level: sequencer, register file and data memory.
// Each transfer on the input channel executes one instruction at the current
// PC and produces one result. ALU, branch, jump and CSR instructions read
// the register file, then execute; loads and stores read the data memory
// word, then merge it and, for stores, write it back; multiplies wait on the
// multiply unit, and divides and remainders on 32 steps of the restoring divider. A new instruction
// is taken once the previous one has finished and its result has a free
// output slot. The register file and data memory are synchronous RAMs;
// data memory words hold no defined value until stored. Writes to reset_pc
// are ignored: reset always restores the default PC.
module rv32im_decode_execute
    import rvde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_pc,
    output logic [4:0]  o_rd_index,
    output logic [31:0] o_rd_value,
    output logic        o_rd_written,
    output logic [1:0]  o_status,
    output logic [31:0] o_halt_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_MEM  = 2'd2;
    localparam logic [1:0] S_MD   = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [31:0] r_pc, r_ins, r_dmem_base;
    logic [31:0] r_mstatus, r_mtvec, r_mepc, r_mcause;
    logic        r_halted;
    logic [31:0] r_vld;
    logic [4:0]  r_ra1, r_ra2;
    logic [DMEM_AW-1:0] r_word;
    logic [1:0]  r_lane;

    logic        r_o_valid, r_o_wr;
    logic [31:0] r_o_npc, r_o_val, r_o_halt;
    logic [4:0]  r_o_rd;
    logic [1:0]  r_o_status;

    logic        accept;
    logic [4:0]  ra1;
    logic [31:0] q1, q2, a, b;

    // decode fields
    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [11:0] csr;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, addr, off;
    logic        take, misal, bad_range;

    // decode-stage outcome
    logic        d_fin, d_wr, d_mem, d_md, d_ecall, d_csrw;
    logic [1:0]  d_status;
    logic [31:0] d_val, d_npc;

    // finishing values
    logic        fin, f_wr;
    logic [1:0]  f_status;
    logic [31:0] f_val, f_npc, f_halt;

    // memory stage
    logic [31:0] dm_q, lv, smask, sdata;
    logic        dm_we;
    logic [4:0]  lsh;

    t_md_req     md_req;
    logic        md_done;
    logic [31:0] md_res;

    assign accept      = i_valid & ~o_stall;
    assign o_stall     = (r_state != S_IDLE) | (r_o_valid & i_stall);
    assign o_cfg_ready = 1'b1;

    assign ra1 = (r_halted || i_instr == INSN_EBREAK) ? REG_A0 : i_instr[19:15];

    rvde_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
        .i_clk(i_clk), .i_we(fin & f_wr), .i_waddr(rd), .i_wdata(f_val),
        .i_re(accept), .i_raddr(ra1), .o_rdata(q1)
    );
    rvde_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
        .i_clk(i_clk), .i_we(fin & f_wr), .i_waddr(rd), .i_wdata(f_val),
        .i_re(accept), .i_raddr(i_instr[24:20]), .o_rdata(q2)
    );

    // registers never written read as zero
    assign a = r_vld[r_ra1] ? q1 : 32'd0;
    assign b = r_vld[r_ra2] ? q2 : 32'd0;

    assign op  = r_ins[6:0];
    assign rd  = r_ins[11:7];
    assign f3  = r_ins[14:12];
    assign f7  = r_ins[31:25];
    assign csr = r_ins[31:20];

    assign imm_i = {{20{r_ins[31]}}, r_ins[31:20]};
    assign imm_s = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
    assign imm_b = {{19{r_ins[31]}}, r_ins[31], r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};
    assign imm_j = {{11{r_ins[31]}}, r_ins[31], r_ins[19:12], r_ins[20], r_ins[30:21], 1'b0};

    assign addr  = a + ((op == OP_STORE) ? imm_s : imm_i);
    assign off   = addr - r_dmem_base;
    assign misal = ((f3[1:0] == 2'd1) && (addr[0] || off[0]))
                 || ((f3[1:0] == 2'd2) && (addr[1:0] != 2'd0 || off[1:0] != 2'd0));
    always_comb begin
        case (f3[1:0])
            2'd0:    bad_range = off > (DMEM_BYTES - 32'd1);
            2'd1:    bad_range = off > (DMEM_BYTES - 32'd2);
            default: bad_range = off > (DMEM_BYTES - 32'd4);
        endcase
    end

    always_comb begin
        case (f3)
            3'd0:    take = (a == b);
            3'd1:    take = (a != b);
            3'd4:    take = $signed(a) < $signed(b);
            3'd5:    take = !($signed(a) < $signed(b));
            3'd6:    take = a < b;
            default: take = a >= b;
        endcase
    end

    always_comb begin
        d_fin    = 1'b1;
        d_wr     = 1'b0;
        d_mem    = 1'b0;
        d_md     = 1'b0;
        d_ecall  = 1'b0;
        d_csrw   = 1'b0;
        d_status = ST_OK;
        d_val    = '0;
        d_npc    = r_pc + 32'd4;
        if (r_halted) begin
            // hold the PC while halted
            d_status = ST_HALT;
            d_npc    = r_pc;
        end else begin
            case (op)
                OP_LUI: begin
                    d_val = {r_ins[31:12], 12'd0};
                    d_wr  = 1'b1;
                end
                OP_AUIPC: begin
                    d_val = r_pc + {r_ins[31:12], 12'd0};
                    d_wr  = 1'b1;
                end
                OP_JAL: begin
                    d_val = r_pc + 32'd4;
                    d_wr  = 1'b1;
                    d_npc = r_pc + imm_j;
                end
                OP_JALR: begin
                    if (f3 != 3'd0) begin
                        d_status = ST_ILLEGAL;
                    end else begin
                        d_val = r_pc + 32'd4;
                        d_wr  = 1'b1;
                        d_npc = (a + imm_i) & ~32'd1;
                    end
                end
                OP_BRANCH: begin
                    if (f3 == 3'd2 || f3 == 3'd3) begin
                        d_status = ST_ILLEGAL;
                    end else if (take) begin
                        d_npc = r_pc + imm_b;
                    end
                end
                OP_LOAD: begin
                    if (f3 == 3'd3 || f3 > 3'd5) begin
                        d_status = ST_ILLEGAL;
                    end else if (misal || bad_range) begin
                        d_status = ST_BADMEM;
                    end else begin
                        d_fin = 1'b0;
                        d_mem = 1'b1;
                    end
                end
                OP_STORE: begin
                    if (f3 > 3'd2) begin
                        d_status = ST_ILLEGAL;
                    end else if (misal || bad_range) begin
                        d_status = ST_BADMEM;
                    end else begin
                        d_fin = 1'b0;
                        d_mem = 1'b1;
                    end
                end
                OP_IMM: begin
                    d_wr = 1'b1;
                    case (f3)
                        3'd0: d_val = a + imm_i;
                        3'd2: d_val = {31'd0, $signed(a) < $signed(imm_i)};
                        3'd3: d_val = {31'd0, a < imm_i};
                        3'd4: d_val = a ^ imm_i;
                        3'd6: d_val = a | imm_i;
                        3'd7: d_val = a & imm_i;
                        3'd1: begin
                            if (f7 == F7_ZERO) d_val = a << r_ins[24:20];
                            else               d_status = ST_ILLEGAL;
                        end
                        default: begin
                            if (f7 == F7_ZERO)     d_val = a >> r_ins[24:20];
                            else if (f7 == F7_ALT) d_val = 32'($signed(a) >>> r_ins[24:20]);
                            else                   d_status = ST_ILLEGAL;
                        end
                    endcase
                end
                OP_REG: begin
                    d_wr = 1'b1;
                    if (f7 == F7_ZERO) begin
                        case (f3)
                            3'd0:    d_val = a + b;
                            3'd1:    d_val = a << b[4:0];
                            3'd2:    d_val = {31'd0, $signed(a) < $signed(b)};
                            3'd3:    d_val = {31'd0, a < b};
                            3'd4:    d_val = a ^ b;
                            3'd5:    d_val = a >> b[4:0];
                            3'd6:    d_val = a | b;
                            default: d_val = a & b;
                        endcase
                    end else if (f7 == F7_ALT && f3 == 3'd0) begin
                        d_val = a - b;
                    end else if (f7 == F7_ALT && f3 == 3'd5) begin
                        d_val = 32'($signed(a) >>> b[4:0]);
                    end else if (f7 == F7_MULDIV && f3 != MD_MULHSU) begin
                        d_fin = 1'b0;
                        d_md  = 1'b1;
                    end else begin
                        d_status = ST_ILLEGAL;
                    end
                end
                OP_SYSTEM: begin
                    if (r_ins == INSN_EBREAK) begin
                        d_status = ST_HALT;
                        d_npc    = r_pc;
                    end else if (r_ins == INSN_ECALL) begin
                        d_ecall = 1'b1;
                        d_npc   = r_mtvec;
                    end else if (r_ins == INSN_MRET) begin
                        d_npc = r_mepc;
                    end else if (f3 == 3'd1 && rd == 5'd0) begin
                        d_csrw = 1'b1;
                    end else if (f3 == 3'd2 && r_ins[19:15] == 5'd0) begin
                        d_wr = 1'b1;
                        case (csr)
                            CSR_MSTATUS: d_val = r_mstatus;
                            CSR_MTVEC:   d_val = r_mtvec;
                            CSR_MEPC:    d_val = r_mepc;
                            CSR_MCAUSE:  d_val = r_mcause;
                            default:     d_wr  = 1'b0;
                        endcase
                    end else begin
                        d_status = ST_ILLEGAL;
                    end
                end
                default: d_status = ST_ILLEGAL;
            endcase
            if (d_status != ST_OK) begin
                d_npc = r_pc;
                d_wr  = 1'b0;
            end
        end
    end

    assign md_req.start = (r_state == S_DEC) & d_md;
    assign md_req.f3    = f3;

    rvde_muldiv u_md (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(md_req),
        .i_a(a), .i_b(b), .o_done(md_done), .o_result(md_res)
    );

    // data memory: read at decode, merge and write back in the memory stage
    rvde_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
        .i_clk(i_clk), .i_we(dm_we), .i_waddr(r_word), .i_wdata(sdata),
        .i_re((r_state == S_DEC) & d_mem), .i_raddr(off[DMEM_AW+1:2]), .o_rdata(dm_q)
    );

    assign lsh = {r_lane, 3'd0};
    always_comb begin
        logic [31:0] sh;
        sh = dm_q >> lsh;
        case (f3)
            3'd0:    lv = {{24{sh[7]}}, sh[7:0]};
            3'd1:    lv = {{16{sh[15]}}, sh[15:0]};
            3'd4:    lv = {24'd0, sh[7:0]};
            3'd5:    lv = {16'd0, sh[15:0]};
            default: lv = sh;
        endcase
        case (f3[1:0])
            2'd0:    smask = 32'h0000_00ff << lsh;
            2'd1:    smask = 32'h0000_ffff << lsh;
            default: smask = 32'hffff_ffff;
        endcase
        sdata = (dm_q & ~smask) | ((b << lsh) & smask);
    end
    assign dm_we = (r_state == S_MEM) & (op == OP_STORE);

    always_comb begin
        fin      = 1'b0;
        f_wr     = 1'b0;
        f_status = d_status;
        f_val    = d_val;
        f_npc    = d_npc;
        f_halt   = (d_status == ST_HALT) ? a : 32'd0;
        case (r_state)
            S_DEC: begin
                fin  = d_fin;
                f_wr = d_wr;
            end
            S_MEM: begin
                fin   = 1'b1;
                f_wr  = (op == OP_LOAD);
                f_val = lv;
            end
            S_MD: begin
                fin   = md_done;
                f_wr  = 1'b1;
                f_val = md_res;
            end
            default: fin = 1'b0;
        endcase
        if (rd == 5'd0) begin
            f_wr = 1'b0;
        end
        if (!f_wr) begin
            f_val = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_DEC;
            S_DEC: begin
                if (d_mem)      n_state = S_MEM;
                else if (d_md)  n_state = S_MD;
                else            n_state = S_IDLE;
            end
            S_MEM:   n_state = S_IDLE;
            S_MD:    if (md_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= RESET_PC_DEFAULT;
            r_dmem_base <= DMEM_BASE_DEFAULT;
            r_mstatus   <= '0;
            r_mtvec     <= '0;
            r_mepc      <= '0;
            r_mcause    <= '0;
            r_halted    <= 1'b0;
            r_vld       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && i_cfg_index == CFG_DMEM_BASE) begin
                r_dmem_base <= i_cfg_data;
            end
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (fin) begin
                r_o_valid <= 1'b1;
                r_pc      <= f_npc;
                if (f_wr) begin
                    r_vld[rd] <= 1'b1;
                end
                if (r_state == S_DEC && d_status == ST_HALT) begin
                    r_halted <= 1'b1;
                end
                if (r_state == S_DEC && d_ecall) begin
                    r_mepc   <= r_pc;
                    r_mcause <= CAUSE_ECALL;
                end
                if (r_state == S_DEC && d_csrw) begin
                    case (csr)
                        CSR_MSTATUS: r_mstatus <= a;
                        CSR_MTVEC:   r_mtvec   <= a;
                        CSR_MEPC:    r_mepc    <= a;
                        CSR_MCAUSE:  r_mcause  <= a;
                        default:     r_mstatus <= r_mstatus;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ins <= i_instr;
            r_ra1 <= ra1;
            r_ra2 <= i_instr[24:20];
        end
        if (r_state == S_DEC) begin
            r_word <= off[DMEM_AW+1:2];
            r_lane <= off[1:0];
        end
        if (fin) begin
            r_o_npc    <= f_npc;
            r_o_rd     <= f_wr ? rd : 5'd0;
            r_o_val    <= f_val;
            r_o_wr     <= f_wr;
            r_o_status <= f_status;
            r_o_halt   <= f_halt;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_next_pc    = r_o_npc;
    assign o_rd_index   = r_o_rd;
    assign o_rd_value   = r_o_val;
    assign o_rd_written = r_o_wr;
    assign o_status     = r_o_status;
    assign o_halt_code  = r_o_halt;
endmodule

// ----- rtl/rvde_checker.sv -----
// Port-level checks on the decode-execute block's results, with bind.
module rvde_checker
    import rvde_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_next_pc,
    input logic [4:0]  o_rd_index,
    input logic [31:0] o_rd_value,
    input logic        o_rd_written,
    input logic [1:0]  o_status,
    input logic [31:0] o_halt_code
);
    a_wr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rd_written |-> o_rd_index != 5'd0)
        else $error("register write reported for x0");

    a_no_wr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rd_written |-> o_rd_index == 5'd0 && o_rd_value == 32'd0)
        else $error("destination fields set without a write");

    a_fault_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ILLEGAL || o_status == ST_BADMEM) |-> !o_rd_written)
        else $error("faulting instruction wrote a register");

    a_halt_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_HALT |-> o_halt_code == 32'd0)
        else $error("halt code outside a halt");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_next_pc))
        else $error("stalled result changed");
endmodule

bind rv32im_decode_execute rvde_checker u_rvde_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_next_pc(o_next_pc), .o_rd_index(o_rd_index), .o_rd_value(o_rd_value),
    .o_rd_written(o_rd_written), .o_status(o_status), .o_halt_code(o_halt_code)
);

// ----- tb/sv/tb_rv32im_decode_execute.sv -----
// Self-checking testbench for the RV32IM decode-execute block.
`timescale 1ns / 1ps

module tb_rv32im_decode_execute;
    import rvde_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SQUEEZE_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned MAX_PRINTS     = 40;

    // funct3 codes of the base integer set
    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
    localparam logic [2:0] F3_LB = 3'd0, F3_LH = 3'd1, F3_LW = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4, F3_LHU = 3'd5;
    localparam logic [2:0] F3_CSRRW = 3'd1, F3_CSRRS = 3'd2;
    localparam logic [31:0] INSN_FENCE = 32'h0000_000f;

    typedef struct packed {
        logic [31:0] npc;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        wr;
        logic [1:0]  st;
        logic [31:0] hc;
    } res_t;

    class hart_scoreboard;
        logic [31:0] pc, base, boot_pc;
        logic [31:0] regs[32];
        logic [31:0] mstatus, mtvec, mepc, mcause;
        logic [31:0] mem[DMEM_WORDS];
        bit   [3:0]  filled[DMEM_WORDS];
        bit          halted;
        res_t        results_due[$];
        int          errors, checked, n_illegal, n_badmem, n_halt;

        function new();
            boot_pc = RESET_PC_DEFAULT;
            base    = DMEM_BASE_DEFAULT;
            pc      = RESET_PC_DEFAULT;
            foreach (regs[i]) regs[i] = '0;
            foreach (filled[i]) filled[i] = '0;
            mstatus = '0; mtvec = '0; mepc = '0; mcause = '0;
            halted  = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTS) $display("mismatch: %s", what);
        endtask

        function bit find(logic [31:0] addr, logic [31:0] size,
                          output int unsigned w, output int unsigned lane);
            logic [31:0] off;
            off = addr - base;
            w = 0; lane = 0;
            if ((addr & (size - 1)) != 0 || (off & (size - 1)) != 0) return 0;
            if (off > DMEM_BYTES - size) return 0;
            w = off >> 2;
            lane = off[1:0];
            return 1;
        endfunction

        // True unless the word is a load of bytes that were never stored.
        function bit readable(logic [31:0] ins);
            int unsigned w, lane;
            logic [31:0] size, a;
            a = regs[ins[19:15]];
            if (halted || ins[6:0] != OP_LOAD) return 1;
            if (ins[14:12] == 3'd3 || ins[14:12] > 3'd5) return 1;
            size = 32'd1 << ins[13:12];
            if (!find(a + {{20{ins[31]}}, ins[31:20]}, size, w, lane)) return 1;
            for (int k = 0; k < size; k++)
                if (!filled[w][lane + k]) return 0;
            return 1;
        endfunction

        function res_t execute(logic [31:0] ins);
            res_t r;
            logic [31:0] npc, a, b, v, immI, immS, immB, immJ, m, size;
            logic [63:0] p;
            logic [4:0]  rd;
            logic [2:0]  f3;
            logic [6:0]  f7;
            logic [1:0]  st;
            logic [11:0] csr;
            bit wr, take;
            int unsigned w, lane;
            r = '0;
            rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25]; csr = ins[31:20];
            a = regs[ins[19:15]]; b = regs[ins[24:20]];
            immI = {{20{ins[31]}}, ins[31:20]};
            immS = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            immB = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
            immJ = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
            npc = pc + 4; v = '0; wr = 0; st = ST_OK; take = 0;
            if (halted) begin
                r.npc = pc; r.st = ST_HALT; r.hc = regs[REG_A0];
                n_halt++;
                return r;
            end
            case (ins[6:0])
                OP_LUI: begin v = {ins[31:12], 12'b0}; wr = 1; end
                OP_AUIPC: begin v = pc + {ins[31:12], 12'b0}; wr = 1; end
                OP_JAL: begin v = pc + 4; wr = 1; npc = pc + immJ; end
                OP_JALR: begin
                    if (f3 != 3'd0) st = ST_ILLEGAL;
                    else begin v = pc + 4; wr = 1; npc = (a + immI) & ~32'd1; end
                end
                OP_BRANCH: begin
                    case (f3)
                        F3_BEQ:  take = a == b;
                        F3_BNE:  take = a != b;
                        F3_BLT:  take = $signed(a) < $signed(b);
                        F3_BGE:  take = $signed(a) >= $signed(b);
                        F3_BLTU: take = a < b;
                        F3_BGEU: take = a >= b;
                        default: st = ST_ILLEGAL;
                    endcase
                    if (take) npc = pc + immB;
                end
                OP_LOAD: begin
                    size = 32'd1 << f3[1:0];
                    if (f3 == 3'd3 || f3 > 3'd5) st = ST_ILLEGAL;
                    else if (!find(a + immI, size, w, lane)) st = ST_BADMEM;
                    else begin
                        v = mem[w] >> (lane * 8);
                        if (size == 1) v = f3[2] ? {24'b0, v[7:0]} : {{24{v[7]}}, v[7:0]};
                        else if (size == 2)
                            v = f3[2] ? {16'b0, v[15:0]} : {{16{v[15]}}, v[15:0]};
                        wr = 1;
                    end
                end
                OP_STORE: begin
                    size = 32'd1 << f3[1:0];
                    if (f3 > 3'd2) st = ST_ILLEGAL;
                    else if (!find(a + immS, size, w, lane)) st = ST_BADMEM;
                    else begin
                        m = (size == 4) ? 32'hffff_ffff :
                            (((size == 2) ? 32'hffff : 32'hff) << (lane * 8));
                        mem[w] = (mem[w] & ~m) | ((b << (lane * 8)) & m);
                        for (int k = 0; k < size; k++) filled[w][lane + k] = 1;
                    end
                end
                OP_IMM: begin
                    wr = 1;
                    case (f3)
                        F3_ADD:  v = a + immI;
                        F3_SLT:  v = {31'b0, $signed(a) < $signed(immI)};
                        F3_SLTU: v = {31'b0, a < immI};
                        F3_XOR:  v = a ^ immI;
                        F3_OR:   v = a | immI;
                        F3_AND:  v = a & immI;
                        F3_SLL:  if (f7 == F7_ZERO) v = a << ins[24:20]; else st = ST_ILLEGAL;
                        default: begin
                            if (f7 == F7_ZERO) v = a >> ins[24:20];
                            else if (f7 == F7_ALT) v = $signed(a) >>> ins[24:20];
                            else st = ST_ILLEGAL;
                        end
                    endcase
                end
                OP_REG: begin
                    wr = 1;
                    if (f7 == F7_ZERO) begin
                        case (f3)
                            F3_ADD:  v = a + b;
                            F3_SLL:  v = a << b[4:0];
                            F3_SLT:  v = {31'b0, $signed(a) < $signed(b)};
                            F3_SLTU: v = {31'b0, a < b};
                            F3_XOR:  v = a ^ b;
                            F3_SR:   v = a >> b[4:0];
                            F3_OR:   v = a | b;
                            default: v = a & b;
                        endcase
                    end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                        v = a - b;
                    end else if (f7 == F7_ALT && f3 == F3_SR) begin
                        v = $signed(a) >>> b[4:0];
                    end else if (f7 == F7_MULDIV) begin
                        case (f3)
                            MD_MUL: v = a * b;
                            MD_MULH: begin
                                p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                                v = p[63:32];
                            end
                            MD_MULHU: begin p = {32'b0, a} * {32'b0, b}; v = p[63:32]; end
                            MD_DIV: begin
                                if (b == 0) v = 32'hffff_ffff;
                                else if (a == 32'h8000_0000 && b == 32'hffff_ffff) v = a;
                                else v = $signed(a) / $signed(b);
                            end
                            MD_DIVU: v = (b == 0) ? 32'hffff_ffff : a / b;
                            MD_REM: begin
                                if (b == 0) v = a;
                                else if (a == 32'h8000_0000 && b == 32'hffff_ffff) v = 0;
                                else v = $signed(a) % $signed(b);
                            end
                            MD_REMU: v = (b == 0) ? a : a % b;
                            default: st = ST_ILLEGAL;
                        endcase
                    end else begin
                        st = ST_ILLEGAL;
                    end
                end
                OP_SYSTEM: begin
                    if (ins == INSN_EBREAK) begin
                        halted = 1; st = ST_HALT; r.hc = regs[REG_A0]; npc = pc;
                    end else if (ins == INSN_ECALL) begin
                        mepc = pc; mcause = CAUSE_ECALL; npc = mtvec;
                    end else if (ins == INSN_MRET) begin
                        npc = mepc;
                    end else if (f3 == F3_CSRRW && rd == 0) begin
                        case (csr)
                            CSR_MSTATUS: mstatus = a;
                            CSR_MTVEC:   mtvec = a;
                            CSR_MEPC:    mepc = a;
                            CSR_MCAUSE:  mcause = a;
                            default: ;
                        endcase
                    end else if (f3 == F3_CSRRS && ins[19:15] == 0) begin
                        wr = 1;
                        case (csr)
                            CSR_MSTATUS: v = mstatus;
                            CSR_MTVEC:   v = mtvec;
                            CSR_MEPC:    v = mepc;
                            CSR_MCAUSE:  v = mcause;
                            default:     wr = 0;
                        endcase
                    end else begin
                        st = ST_ILLEGAL;
                    end
                end
                default: st = ST_ILLEGAL;
            endcase
            if (st == ST_ILLEGAL || st == ST_BADMEM) begin npc = pc; wr = 0; end
            if (st == ST_ILLEGAL) n_illegal++;
            if (st == ST_BADMEM) n_badmem++;
            if (!wr || rd == 0) begin wr = 0; rd = 0; v = 0; end
            if (wr) regs[rd] = v;
            regs[0] = '0;
            pc = npc;
            r.npc = npc; r.rd = rd; r.val = v; r.wr = wr; r.st = st;
            return r;
        endfunction

        function void note_input(logic [31:0] ins);
            results_due.push_back(execute(ins));
        endfunction

        task check(res_t got);
            res_t e;
            if (results_due.size() == 0) begin
                report($sformatf("result with nothing pending, next_pc %h", got.npc));
                return;
            end
            e = results_due.pop_front();
            checked++;
            if (got.npc !== e.npc) report($sformatf("next_pc %h, want %h", got.npc, e.npc));
            if (got.rd !== e.rd) report($sformatf("rd_index %0d, want %0d", got.rd, e.rd));
            if (got.val !== e.val) report($sformatf("rd_value %h, want %h", got.val, e.val));
            if (got.wr !== e.wr) report($sformatf("rd_written %b, want %b", got.wr, e.wr));
            if (got.st !== e.st) report($sformatf("status %0d, want %0d", got.st, e.st));
            if (got.hc !== e.hc) report($sformatf("halt_code %h, want %h", got.hc, e.hc));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic [31:0] i_instr = '0;
    logic        i_stall = 0;
    logic        i_cfg_valid = 0;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_stall, o_valid, o_rd_written, o_cfg_ready;
    logic [31:0] o_next_pc, o_rd_value, o_halt_code;
    logic [4:0]  o_rd_index;
    logic [1:0]  o_status;

    hart_scoreboard sb = new();
    bit quiet = 0;
    bit squeeze = 0;
    int sent = 0;
    int unsigned idle_count = 0;

    rv32im_decode_execute dut (.*);

    always #6 i_clk = ~i_clk;

    function logic [31:0] r_type(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                 logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function logic [31:0] i_type(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                 logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function logic [31:0] s_type(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                 logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    // Memory op aimed near either end of the data memory, or a lui that
    // sets up the pointer register first when the offset is out of reach.
    function logic [31:0] gen_mem();
        logic [31:0] off, target, imm, hi, ins;
        logic [4:0]  rs1;
        logic [2:0]  f3;
        int unsigned sz;
        f3  = 3'($urandom_range(0, 2));
        sz  = 1 << f3;
        rs1 = ($urandom_range(0, 4) != 0) ? 5'(8 + $urandom_range(0, 1))
                                          : 5'($urandom_range(1, 31));
        off = $urandom_range(0, 1) ? $urandom_range(0, 127)
                                   : DMEM_BYTES - 1 - $urandom_range(0, 127);
        off = off & ~(sz - 1);
        case ($urandom_range(0, 19))
            0, 1: if (sz > 1) off = off + $urandom_range(1, sz - 1);
            2:    off = DMEM_BYTES + $urandom_range(0, 63);
            3:    off = 32'hffff_fff0 | $urandom_range(0, 15);
            default: ;
        endcase
        target = sb.base + off;
        imm = target - sb.regs[rs1];
        if ($signed(imm) < -2048 || $signed(imm) > 2047) begin
            hi = (target + 32'h800) & 32'hffff_f000;
            return {hi[31:12], rs1, OP_LUI};
        end
        if ($urandom_range(0, 1)) begin
            ins = i_type(imm[11:0], rs1, (sz < 4 && $urandom_range(0, 1)) ? (f3 | 3'd4) : f3,
                         5'($urandom_range(0, 31)), OP_LOAD);
            if (sb.readable(ins)) return ins;
        end
        return s_type(imm[11:0], 5'($urandom_range(0, 31)), rs1, f3);
    endfunction

    function logic [31:0] gen_item();
        logic [31:0] ins;
        logic [4:0]  rd, rs1, rs2;
        logic [11:0] csr;
        rd  = 5'($urandom_range(0, 31));
        rs1 = 5'($urandom_range(0, 31));
        rs2 = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 3))
            0: csr = CSR_MSTATUS;
            1: csr = CSR_MTVEC;
            2: csr = CSR_MEPC;
            default: csr = $urandom_range(0, 1) ? CSR_MCAUSE : 12'($urandom);
        endcase
        case ($urandom_range(0, 19))
            0, 1:    ins = $urandom;
            2, 3:    ins = {20'($urandom), rd, OP_LUI};
            4:       ins = {20'($urandom), rd, OP_AUIPC};
            5, 6:    ins = i_type(12'($urandom), rs1, 3'($urandom_range(0, 7)), rd, OP_IMM);
            7:       ins = i_type({$urandom_range(0, 7) == 0 ? 7'($urandom) :
                                   ($urandom_range(0, 1) ? F7_ALT : F7_ZERO), rs2},
                                  rs1, $urandom_range(0, 1) ? F3_SLL : F3_SR, rd, OP_IMM);
            8, 9:    ins = r_type($urandom_range(0, 1) ? F7_ZERO : F7_ALT, rs2, rs1,
                                  3'($urandom_range(0, 7)), rd);
            10, 11:  ins = r_type(F7_MULDIV, rs2, rs1, 3'($urandom_range(0, 7)), rd);
            12:      ins = {7'($urandom), rs2, rs1, 3'($urandom_range(0, 7)),
                            5'($urandom), OP_BRANCH};
            13:      ins = $urandom_range(0, 1) ? {20'($urandom), rd, OP_JAL}
                           : i_type(12'($urandom), rs1,
                                    $urandom_range(0, 7) == 0 ? 3'($urandom) : 3'd0,
                                    rd, OP_JALR);
            14, 15, 16: ins = gen_mem();
            17:      ins = $urandom_range(0, 1) ? i_type(csr, rs1, F3_CSRRW, 5'd0, OP_SYSTEM)
                           : i_type(csr, 5'd0, F3_CSRRS, rd, OP_SYSTEM);
            18:      ins = $urandom_range(0, 1) ? INSN_ECALL : INSN_MRET;
            default: ins = i_type(12'($urandom), rs1, 3'($urandom_range(0, 7)),
                                  rd, OP_SYSTEM);
        endcase
        if (ins == INSN_EBREAK || !sb.readable(ins))
            ins = i_type(12'($urandom), rs1, F3_XOR, rd, OP_IMM);
        return ins;
    endfunction

    // Offer one instruction and hold it until the block takes it.
    task send(logic [31:0] ins);
        i_valid <= 1;
        i_instr <= ins;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(ins);
        sent++;
        if (sent == 600) squeeze = 1;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task cfg_write(logic [7:0] idx, logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        if (idx == CFG_RESET_PC) sb.boot_pc = data;
        else if (idx == CFG_DMEM_BASE) sb.base = data;
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every pending result is back.
    task drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver side: random stall bursts, one long hold-off to fill the block.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (squeeze) begin
                i_stall <= 1;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
                squeeze = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_stall <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check({o_next_pc, o_rd_index, o_rd_value, o_rd_written, o_status, o_halt_code});
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [31:0] bases[6];
        logic [31:0] boots[6];
        bases = '{DMEM_BASE_DEFAULT, 32'h0, 32'hffff_ffff, 32'hffff_c000, $urandom,
                  DMEM_BASE_DEFAULT};
        boots = '{$urandom, 32'h0, 32'hffff_ffff, $urandom, RESET_PC_DEFAULT, $urandom};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(CFG_RESET_PC, boots[ph]);
            cfg_write(CFG_DMEM_BASE, bases[ph]);
            if (ph == 0) begin
                send({20'h80000, 5'd1, OP_LUI});
                send(i_type(12'hfff, 5'd0, F3_ADD, 5'd2, OP_IMM));
                send(s_type(12'd0, 5'd2, 5'd1, F3_LW));
                send(i_type(12'd0, 5'd1, F3_LB, 5'd3, OP_LOAD));
                send(i_type(12'd2, 5'd1, F3_LHU, 5'd4, OP_LOAD));
                send(i_type(12'd1, 5'd1, F3_LW, 5'd13, OP_LOAD));   // misaligned
                send(r_type(F7_MULDIV, 5'd2, 5'd1, MD_DIV, 5'd5));   // signed overflow
                send(r_type(F7_MULDIV, 5'd2, 5'd1, MD_REM, 5'd6));
                send(r_type(F7_MULDIV, 5'd0, 5'd1, MD_DIVU, 5'd7));  // divide by zero
                send(r_type(F7_MULDIV, 5'd0, 5'd1, MD_REMU, 5'd8));
                send(r_type(F7_MULDIV, 5'd2, 5'd1, MD_MULH, 5'd9));
                send(r_type(F7_MULDIV, 5'd2, 5'd1, MD_MULHU, 5'd11));
                send(r_type(F7_MULDIV, 5'd2, 5'd2, MD_MUL, 5'd12));
                send(r_type(F7_MULDIV, 5'd2, 5'd1, MD_MULHSU, 5'd12));
                send(i_type(12'd0, 5'd2, F3_SLT, 5'd14, OP_IMM));
                send(r_type(F7_ZERO, 5'd2, 5'd2, F3_SR, 5'd15));     // shift masked to 31
                send(i_type({F7_ALT, 5'd3}, 5'd2, F3_SLL, 5'd16, OP_IMM));
                send(INSN_FENCE);
                send(i_type(CSR_MTVEC, 5'd1, F3_CSRRW, 5'd0, OP_SYSTEM));
                send(i_type(CSR_MTVEC, 5'd0, F3_CSRRS, 5'd17, OP_SYSTEM));
                send(i_type(12'h7c0, 5'd0, F3_CSRRS, 5'd18, OP_SYSTEM));
                send(INSN_ECALL);
                send(i_type(CSR_MEPC, 5'd0, F3_CSRRS, 5'd19, OP_SYSTEM));
                send(INSN_MRET);
                send(i_type(12'd5, 5'd2, F3_ADD, 5'd0, OP_IMM));
            end
            quiet = (ph == 5);
            for (int n = 0; n < 330; n++) send(gen_item());
            drain();
        end

        // halt, then confirm the block stays halted
        send(i_type(12'd123, 5'd0, F3_ADD, REG_A0, OP_IMM));
        send(INSN_EBREAK);
        send(gen_item());
        send($urandom);
        drain();

        $display("ran %0d instructions over 6 memory bases, %0d results checked",
                 sent, sb.checked);
        $display("illegal %0d, bad memory %0d, halted %0d, mismatches %0d",
                 sb.n_illegal, sb.n_badmem, sb.n_halt, sb.errors);
        if (sb.errors == 0 && sb.results_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rvde_pkg.sv
rtl/rvde_ram.sv
rtl/rvde_muldiv.sv
rtl/rv32im_decode_execute.sv
rtl/rvde_checker.sv
tb/sv/tb_rv32im_decode_execute.sv
